// ----- rtl/bls_pkg.sv -----
// bounded lifo stack: shared types, codes and constants
// no dependencies; used by bls_seq and bounded_lifo_stack_unit

package bls_pkg;

  localparam int unsigned MAX_DEPTH = 64;
  localparam int unsigned CAP_W     = 7;
  localparam int unsigned WORD_W    = 32;
  localparam logic [CAP_W-1:0]  CAP_RESET = 7'd64;
  localparam logic [WORD_W-1:0] FAIL_WORD = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] ZERO_WORD = 32'h0000_0000;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_POP  = 3'd1,
    OP_PEEK = 3'd2,
    OP_TOP  = 3'd3,
    OP_PAL  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_BADPOS    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_PAL_LO,
    ST_PAL_HI,
    ST_RESP
  } state_e;

  typedef struct packed {
    op_e                      operation;
    logic signed [WORD_W-1:0] push_value;
    logic [CAP_W-1:0]         depth_from_top;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_data;
    status_e                  status;
    logic                     is_palindrome;
    logic                     empty_flag;
    logic                     full_flag;
    logic [CAP_W-1:0]         entry_count;
  } rsp_t;

endpackage

// ----- rtl/bls_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies

module bls_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/bls_seq.sv -----
// stack sequencer: request decode, fill count, palindrome walk, result register
// depends on bls_pkg; drives the ports of one bls_ram

module bls_seq #(
  parameter int unsigned MaxDepth = bls_pkg::MAX_DEPTH,
  localparam int unsigned AW = $clog2(MaxDepth),
  localparam int unsigned CW = $clog2(MaxDepth + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  bls_pkg::req_t                in_req_i,
  output logic                         in_stall_o,
  output logic                         out_valid_o,
  output bls_pkg::rsp_t                out_rsp_o,
  input  logic                         out_stall_i,
  input  logic [bls_pkg::CAP_W-1:0]    cap_i,
  output logic                         ram_we_o,
  output logic [AW-1:0]                ram_waddr_o,
  output logic [bls_pkg::WORD_W-1:0]   ram_wdata_o,
  output logic [AW-1:0]                ram_raddr_o,
  input  logic [bls_pkg::WORD_W-1:0]   ram_rdata_i
);

  localparam int unsigned EW = (CW > bls_pkg::CAP_W) ? CW : bls_pkg::CAP_W;

  bls_pkg::state_e state_q, state_d;
  bls_pkg::req_t   req_q, req_d;
  bls_pkg::rsp_t   out_q, out_d;
  bls_pkg::status_e stat_q, stat_d;
  logic                        out_valid_q, out_valid_d;
  logic [CW-1:0]               count_q, count_d;
  logic [CW-1:0]               lo_q, lo_d;
  logic [CW-1:0]               hi_q, hi_d;
  logic [bls_pkg::WORD_W-1:0]  lo_word_q, lo_word_d;
  logic [bls_pkg::WORD_W-1:0]  data_q, data_d;
  logic                        pal_q, pal_d;

  logic          in_accept;
  logic          load_out;
  logic [EW-1:0] cnt_ext;
  logic [EW-1:0] cap_eff;
  logic [EW-1:0] peek_addr;
  logic [CW-1:0] cnt_dec;
  logic [CW-1:0] lo_next;
  logic          is_full;
  logic          is_empty;
  logic          depth_bad;
  logic          pal_short;
  logic          pal_more;
  logic          words_eq;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != bls_pkg::ST_IDLE);
  assign load_out = (state_q == bls_pkg::ST_RESP) && (!out_valid_q || !out_stall_i);

  assign cnt_ext   = EW'(count_q);
  assign cap_eff   = (EW'(cap_i) > EW'(MaxDepth)) ? EW'(MaxDepth) : EW'(cap_i);
  assign is_full   = cnt_ext >= cap_eff;
  assign is_empty  = (count_q == '0);
  assign depth_bad = (req_q.depth_from_top == '0) || (EW'(req_q.depth_from_top) > cnt_ext);
  assign peek_addr = cnt_ext - EW'(req_q.depth_from_top);
  assign cnt_dec   = count_q - CW'(1);
  assign pal_short = count_q < CW'(2);
  assign lo_next   = lo_q + CW'(1);
  assign pal_more  = hi_q > (lo_next + CW'(1));
  assign words_eq  = (ram_rdata_i == lo_word_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bls_pkg::ST_IDLE: begin
        if (in_accept) state_d = bls_pkg::ST_EXEC;
      end
      bls_pkg::ST_EXEC: begin
        unique case (req_q.operation)
          bls_pkg::OP_PUSH: state_d = bls_pkg::ST_RESP;
          bls_pkg::OP_POP,
          bls_pkg::OP_TOP:  state_d = is_empty ? bls_pkg::ST_RESP : bls_pkg::ST_READ;
          bls_pkg::OP_PEEK: state_d = depth_bad ? bls_pkg::ST_RESP : bls_pkg::ST_READ;
          bls_pkg::OP_PAL: begin
            state_d = (is_empty || pal_short) ? bls_pkg::ST_RESP : bls_pkg::ST_PAL_LO;
          end
          default:          state_d = bls_pkg::ST_RESP;
        endcase
      end
      bls_pkg::ST_READ:   state_d = bls_pkg::ST_RESP;
      bls_pkg::ST_PAL_LO: state_d = bls_pkg::ST_PAL_HI;
      bls_pkg::ST_PAL_HI: begin
        state_d = (words_eq && pal_more) ? bls_pkg::ST_PAL_LO : bls_pkg::ST_RESP;
      end
      bls_pkg::ST_RESP: begin
        if (load_out) state_d = bls_pkg::ST_IDLE;
      end
      default: state_d = bls_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    req_d       = req_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    lo_word_d   = lo_word_q;
    data_d      = data_q;
    stat_d      = stat_q;
    pal_d       = pal_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = count_q[AW-1:0];
    ram_wdata_o = req_q.push_value;
    ram_raddr_o = '0;

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    unique case (state_q)
      bls_pkg::ST_IDLE: begin
        if (in_accept) req_d = in_req_i;
      end
      bls_pkg::ST_EXEC: begin
        data_d = bls_pkg::FAIL_WORD;
        stat_d = bls_pkg::STAT_BADPOS;
        pal_d  = 1'b0;
        unique case (req_q.operation)
          bls_pkg::OP_PUSH: begin
            if (is_full) begin
              stat_d = bls_pkg::STAT_OVERFLOW;
            end else begin
              ram_we_o = 1'b1;
              count_d  = count_q + CW'(1);
              data_d   = bls_pkg::ZERO_WORD;
              stat_d   = bls_pkg::STAT_OK;
            end
          end
          bls_pkg::OP_POP: begin
            if (is_empty) begin
              stat_d = bls_pkg::STAT_UNDERFLOW;
            end else begin
              count_d     = cnt_dec;
              ram_raddr_o = cnt_dec[AW-1:0];
              stat_d      = bls_pkg::STAT_OK;
            end
          end
          bls_pkg::OP_PEEK: begin
            if (!depth_bad) begin
              ram_raddr_o = peek_addr[AW-1:0];
              stat_d      = bls_pkg::STAT_OK;
            end
          end
          bls_pkg::OP_TOP: begin
            if (is_empty) begin
              stat_d = bls_pkg::STAT_UNDERFLOW;
            end else begin
              ram_raddr_o = cnt_dec[AW-1:0];
              stat_d      = bls_pkg::STAT_OK;
            end
          end
          bls_pkg::OP_PAL: begin
            pal_d = 1'b1;
            if (is_empty) begin
              stat_d = bls_pkg::STAT_UNDERFLOW;
            end else begin
              data_d      = bls_pkg::ZERO_WORD;
              stat_d      = bls_pkg::STAT_OK;
              lo_d        = '0;
              hi_d        = cnt_dec;
              ram_raddr_o = '0;
            end
          end
          default: begin
            stat_d = bls_pkg::STAT_BADPOS;
          end
        endcase
      end
      bls_pkg::ST_READ: begin
        data_d = ram_rdata_i;
      end
      bls_pkg::ST_PAL_LO: begin
        lo_word_d   = ram_rdata_i;
        ram_raddr_o = hi_q[AW-1:0];
      end
      bls_pkg::ST_PAL_HI: begin
        if (!words_eq) begin
          pal_d = 1'b0;
        end else begin
          lo_d = lo_next;
          if (pal_more) begin
            hi_d        = hi_q - CW'(1);
            ram_raddr_o = lo_next[AW-1:0];
          end
        end
      end
      bls_pkg::ST_RESP: begin
        if (load_out) begin
          out_valid_d         = 1'b1;
          out_d.read_data     = data_q;
          out_d.status        = stat_q;
          out_d.is_palindrome = pal_q;
          out_d.empty_flag    = is_empty;
          out_d.full_flag     = is_full;
          out_d.entry_count   = cnt_ext[bls_pkg::CAP_W-1:0];
        end
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bls_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    out_q     <= out_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    lo_word_q <= lo_word_d;
    data_q    <= data_d;
    stat_q    <= stat_d;
    pal_q     <= pal_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    EW'(count_q) <= EW'(MaxDepth))
    else $error("fill count beyond storage");

  a_count_only_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != bls_pkg::ST_EXEC) |=> $stable(count_q))
    else $error("fill count moved outside decode");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> (cnt_ext < cap_eff))
    else $error("storage written while full");

  a_walk_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bls_pkg::ST_PAL_LO || state_q == bls_pkg::ST_PAL_HI)
      |-> (lo_q < hi_q) && (hi_q < count_q))
    else $error("palindrome walk pointers out of order");

  a_out_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (state_q == bls_pkg::ST_IDLE) && out_valid_q)
    else $error("result load did not release the sequencer");

endmodule

// ----- rtl/bounded_lifo_stack_unit.sv -----
// Bounded LIFO stack of signed 32-bit words with programmable capacity.
// One request in flight: a push or failing request passes through ST_EXEC and ST_RESP, a
// pop, peek or read-top also through ST_READ; a palindrome check reads each compared entry
// pair in ST_PAL_LO and ST_PAL_HI (up to count/2 pairs) on the entry ram's single read port.
// The next request is accepted once the result is in the output register.
// Reset clears the fill count and sets capacity to 64; the entry ram is not cleared.

module bounded_lifo_stack_unit #(
  parameter int unsigned MaxDepth = bls_pkg::MAX_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  bls_pkg::req_t             in_req_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  output bls_pkg::rsp_t             out_rsp_o,
  input  logic                      out_stall_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [bls_pkg::CAP_W-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(MaxDepth);

  logic [bls_pkg::CAP_W-1:0]  cap_q, cap_d;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [bls_pkg::WORD_W-1:0] ram_wdata;
  logic [AW-1:0]              ram_raddr;
  logic [bls_pkg::WORD_W-1:0] ram_rdata;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cap_d = cap_q;
    if (cfg_valid_i && cfg_ready_o) cap_d = cfg_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= bls_pkg::CAP_RESET;
    end else begin
      cap_q <= cap_d;
    end
  end

  bls_seq #(
    .MaxDepth (MaxDepth)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o),
    .out_stall_i (out_stall_i),
    .cap_i       (cap_q),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  bls_ram #(
    .Width (bls_pkg::WORD_W),
    .Depth (MaxDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ----- test/tb_bounded_lifo_stack_unit.sv -----
// testbench for bounded_lifo_stack_unit: directed table plus random request bursts, every response
// checked against the table's expected response or an in-bench stack predictor
// depends on rtl/bls_pkg.sv and rtl/bounded_lifo_stack_unit.sv

module tb_bounded_lifo_stack_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bls_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600_000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned NUM_PHASES  = 9;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t rsp;
  } dir_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  req_t             in_req_i = '0;
  logic             in_stall_o;
  logic             out_valid_o;
  rsp_t             out_rsp_o;
  logic             out_stall_i = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CAP_W-1:0] cfg_data_i = '0;

  logic [WORD_W-1:0] shadow_words [MAX_DEPTH];
  int unsigned       shadow_count = 0;
  int unsigned       shadow_cap = CAP_RESET;
  rsp_t              pending_rsps [$];
  int unsigned       error_count = 0;
  int unsigned       sent_reqs = 0;
  int unsigned       cycle_count = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       rsp_idle_pct = 0;
  int unsigned       hold_left = 0;
  bit                hold_go = 1'b0;
  bit                hold_done = 1'b0;
  rsp_t              want_rsp;

  dir_row_t dir_rows [25] = '{
    '{'{OP_POP,  32'sh0, 7'd0},   1'b1, '{FAIL_WORD, STAT_UNDERFLOW, 1'b0, 1'b1, 1'b0, 7'd0}},
    '{'{OP_TOP,  32'sh0, 7'd0},   1'b1, '{FAIL_WORD, STAT_UNDERFLOW, 1'b0, 1'b1, 1'b0, 7'd0}},
    '{'{OP_PEEK, 32'sh0, 7'd1},   1'b1, '{FAIL_WORD, STAT_BADPOS, 1'b0, 1'b1, 1'b0, 7'd0}},
    '{'{OP_PAL,  32'sh0, 7'd0},   1'b1, '{FAIL_WORD, STAT_UNDERFLOW, 1'b1, 1'b1, 1'b0, 7'd0}},
    '{'{op_e'(3'd5), -32'sh1, 7'd127}, 1'b1,
      '{FAIL_WORD, STAT_BADPOS, 1'b0, 1'b1, 1'b0, 7'd0}},
    '{'{op_e'(3'd6), 32'sh0, 7'd0}, 1'b1, '{FAIL_WORD, STAT_BADPOS, 1'b0, 1'b1, 1'b0, 7'd0}},
    '{'{op_e'(3'd7), 32'sh0, 7'd64}, 1'b1, '{FAIL_WORD, STAT_BADPOS, 1'b0, 1'b1, 1'b0, 7'd0}},
    '{'{OP_PUSH, 32'sh7FFF_FFFF, 7'd0}, 1'b1, '{ZERO_WORD, STAT_OK, 1'b0, 1'b0, 1'b0, 7'd1}},
    '{'{OP_PAL,  32'sh0, 7'd0},   1'b1, '{ZERO_WORD, STAT_OK, 1'b1, 1'b0, 1'b0, 7'd1}},
    '{'{OP_PUSH, 32'sh8000_0000, 7'd0}, 1'b1, '{ZERO_WORD, STAT_OK, 1'b0, 1'b0, 1'b0, 7'd2}},
    '{'{OP_PEEK, 32'sh0, 7'd0},   1'b1, '{FAIL_WORD, STAT_BADPOS, 1'b0, 1'b0, 1'b0, 7'd2}},
    '{'{OP_PEEK, 32'sh0, 7'd2},   1'b1,
      '{32'sh7FFF_FFFF, STAT_OK, 1'b0, 1'b0, 1'b0, 7'd2}},
    '{'{OP_PEEK, 32'sh0, 7'd3},   1'b1, '{FAIL_WORD, STAT_BADPOS, 1'b0, 1'b0, 1'b0, 7'd2}},
    '{'{OP_PEEK, 32'sh0, 7'd127}, 1'b1, '{FAIL_WORD, STAT_BADPOS, 1'b0, 1'b0, 1'b0, 7'd2}},
    '{'{OP_TOP,  32'sh0, 7'd0},   1'b1,
      '{32'sh8000_0000, STAT_OK, 1'b0, 1'b0, 1'b0, 7'd2}},
    '{'{OP_PAL,  32'sh0, 7'd0},   1'b1, '{ZERO_WORD, STAT_OK, 1'b0, 1'b0, 1'b0, 7'd2}},
    '{'{OP_PUSH, 32'sh7FFF_FFFF, 7'd0}, 1'b0, '0},
    '{'{OP_PAL,  32'sh0, 7'd0},   1'b0, '0},
    '{'{OP_PUSH, -32'sh1, 7'd0},  1'b0, '0},
    '{'{OP_PEEK, 32'sh0, 7'd64},  1'b0, '0},
    '{'{OP_POP,  32'sh0, 7'd0},   1'b0, '0},
    '{'{OP_POP,  32'sh0, 7'd0},   1'b0, '0},
    '{'{OP_POP,  32'sh0, 7'd0},   1'b0, '0},
    '{'{OP_POP,  32'sh0, 7'd0},   1'b0, '0},
    '{'{OP_POP,  32'sh0, 7'd0},   1'b1, '{FAIL_WORD, STAT_UNDERFLOW, 1'b0, 1'b1, 1'b0, 7'd0}}
  };

  int unsigned phase_caps [NUM_PHASES] = '{1, 0, 127, 64, 2, 7, 64, 33, 3};

  bounded_lifo_stack_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin : clock_gen
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned cap_limit();
    return (shadow_cap > MAX_DEPTH) ? MAX_DEPTH : shadow_cap;
  endfunction

  function automatic rsp_t stack_step(req_t r);
    rsp_t        o;
    int unsigned lim;
    int unsigned lo;
    int unsigned hi;
    bit          same;
    lim = cap_limit();
    o = '0;
    o.status = STAT_OK;
    o.read_data = ZERO_WORD;
    case (r.operation)
      OP_PUSH: begin
        if (shadow_count >= lim) begin
          o.status = STAT_OVERFLOW;
          o.read_data = FAIL_WORD;
        end else begin
          shadow_words[shadow_count] = r.push_value;
          shadow_count++;
        end
      end
      OP_POP: begin
        if (shadow_count == 0) begin
          o.status = STAT_UNDERFLOW;
          o.read_data = FAIL_WORD;
        end else begin
          shadow_count--;
          o.read_data = shadow_words[shadow_count];
        end
      end
      OP_PEEK: begin
        if (r.depth_from_top == 0 || r.depth_from_top > shadow_count) begin
          o.status = STAT_BADPOS;
          o.read_data = FAIL_WORD;
        end else begin
          o.read_data = shadow_words[shadow_count - r.depth_from_top];
        end
      end
      OP_TOP: begin
        if (shadow_count == 0) begin
          o.status = STAT_UNDERFLOW;
          o.read_data = FAIL_WORD;
        end else begin
          o.read_data = shadow_words[shadow_count - 1];
        end
      end
      OP_PAL: begin
        if (shadow_count == 0) begin
          o.status = STAT_UNDERFLOW;
          o.read_data = FAIL_WORD;
          o.is_palindrome = 1'b1;
        end else begin
          lo = 0;
          hi = shadow_count;
          same = 1'b1;
          while (hi > lo + 1) begin
            hi--;
            if (shadow_words[lo] != shadow_words[hi]) same = 1'b0;
            lo++;
          end
          o.is_palindrome = same;
        end
      end
      default: begin
        o.status = STAT_BADPOS;
        o.read_data = FAIL_WORD;
      end
    endcase
    o.empty_flag = (shadow_count == 0);
    o.full_flag = (shadow_count >= lim);
    o.entry_count = shadow_count[CAP_W-1:0];
    return o;
  endfunction

  function automatic req_t make_req(op_e op, logic [WORD_W-1:0] w, logic [CAP_W-1:0] d);
    req_t r;
    r.operation = op;
    r.push_value = w;
    r.depth_from_top = d;
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    return ($urandom_range(0, 3) == 0) ? WORD_W'($urandom_range(0, 3)) : $urandom;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_req(req_t r, bit typed, rsp_t typed_rsp);
    rsp_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    predicted = stack_step(r);
    pending_rsps.push_back(typed ? typed_rsp : predicted);
    sent_reqs++;
    @(negedge clk_i);
  endtask

  task automatic send_rand(op_e op, logic [CAP_W-1:0] d);
    send_req(make_req(op, rand_word(), d), 1'b0, '0);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_rsps.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_capacity(int unsigned cap);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= cap[CAP_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_cap = cap;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic report_mismatch(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] exp);
    if (error_count < 40) begin
      $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, exp);
    end
    error_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_rsps.size() == 0) begin
        report_mismatch("unexpected response", out_rsp_o.read_data, '0);
      end else begin
        want_rsp = pending_rsps.pop_front();
        if (out_rsp_o.read_data !== want_rsp.read_data)
          report_mismatch("read_data", out_rsp_o.read_data, want_rsp.read_data);
        if (out_rsp_o.status !== want_rsp.status)
          report_mismatch("status", out_rsp_o.status, want_rsp.status);
        if (out_rsp_o.is_palindrome !== want_rsp.is_palindrome)
          report_mismatch("is_palindrome", out_rsp_o.is_palindrome, want_rsp.is_palindrome);
        if (out_rsp_o.empty_flag !== want_rsp.empty_flag)
          report_mismatch("empty_flag", out_rsp_o.empty_flag, want_rsp.empty_flag);
        if (out_rsp_o.full_flag !== want_rsp.full_flag)
          report_mismatch("full_flag", out_rsp_o.full_flag, want_rsp.full_flag);
        if (out_rsp_o.entry_count !== want_rsp.entry_count)
          report_mismatch("entry_count", out_rsp_o.entry_count, want_rsp.entry_count);
      end
    end
  end

  // response side stall, with a long hold-off on request
  initial begin : rsp_side
    forever begin
      @(negedge clk_i);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < rsp_idle_pct);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int unsigned     phase_end;
    int unsigned     pick;
    int unsigned     len;
    int              bad;
    int unsigned     n;
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] half [10];
    logic [CAP_W-1:0]  d;
    op_e             op;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_capacity(phase_caps[p]);
      if (p < 3) begin
        send_idle_pct = 13;
        rsp_idle_pct = 54;
      end else if (p < 6) begin
        send_idle_pct = 54;
        rsp_idle_pct = 13;
      end else begin
        send_idle_pct = 0;
        rsp_idle_pct = 0;
      end
      if (p == 6) hold_go = 1'b1;
      phase_end = sent_reqs + 80;
      while (sent_reqs < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          // drain, build a mirrored sequence, maybe spoil one word, then check
          while (shadow_count > 0) send_rand(OP_POP, '0);
          n = cap_limit();
          len = (n > 10) ? $urandom_range(1, 10) : ((n == 0) ? 1 : $urandom_range(1, n));
          for (int i = 0; i < 10; i++) half[i] = rand_word();
          bad = ($urandom_range(0, 1) == 1) ? int'($urandom_range(0, len - 1)) : -1;
          for (int i = 0; i < len; i++) begin
            w = (i < (len + 1) / 2) ? half[i] : half[len - 1 - i];
            if (i == bad) w = w ^ (32'h1 << $urandom_range(0, 31));
            send_req(make_req(OP_PUSH, w, '0), 1'b0, '0);
          end
          send_rand(OP_PAL, '0);
          send_rand(OP_PEEK, CAP_W'($urandom_range(0, shadow_count + 1)));
          send_rand(OP_TOP, '0);
        end else if (pick < 45) begin
          // fill to the limit and one past it
          n = cap_limit();
          while (shadow_count < n) send_rand(OP_PUSH, '0);
          send_rand(OP_PUSH, '0);
          send_rand(OP_PAL, '0);
          send_rand(OP_PEEK, shadow_count[CAP_W-1:0]);
          send_rand(OP_TOP, '0);
        end else begin
          n = $urandom_range(6, 12);
          for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 38) op = OP_PUSH;
            else if (pick < 58) op = OP_POP;
            else if (pick < 73) op = OP_PEEK;
            else if (pick < 83) op = OP_TOP;
            else if (pick < 94) op = OP_PAL;
            else op = op_e'($urandom_range(5, 7));
            if ($urandom_range(0, 9) < 7) d = CAP_W'($urandom_range(0, shadow_count + 1));
            else d = CAP_W'($urandom_range(0, 127));
            send_rand(op, d);
          end
        end
      end
    end

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (error_count == 0 && pending_rsps.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
